// File: sv/ghash_block_update_top_macros.svh
// Assertion macros for the GHASH block update.
`ifndef GHASH_BLOCK_UPDATE_TOP_MACROS_SVH
`define GHASH_BLOCK_UPDATE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Consequence holds in the same cycle as the antecedent.
`define GBU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbu check failed");
// Consequence holds in the cycle after the antecedent.
`define GBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbu check failed");
`else
`define GBU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GBU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/gbu_pkg.sv
// Types, codes and field helpers for the GHASH block update.
`default_nettype none
package gbu_pkg;

  localparam logic [1:0] OP_ABSORB   = 2'd0;
  localparam logic [1:0] OP_MULTIPLY = 2'd1;
  localparam logic [1:0] OP_LOAD     = 2'd2;

  localparam logic [0:0] CFG_KEY_LOW  = 1'b0;
  localparam logic [0:0] CFG_KEY_HIGH = 1'b1;

  localparam logic [7:0]   REDUCE_POLY = 8'h87;
  localparam int           DIGIT_BITS  = 8;
  localparam int           DIGITS      = 128 / DIGIT_BITS;
  localparam int           CNT_W       = $clog2(DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] block_low;
    logic [63:0] block_high;
  } gbu_in_t;

  typedef struct packed {
    logic [63:0] acc_low;
    logic [63:0] acc_high;
  } gbu_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_HOLD
  } gbu_state_t;

  // Reverse bit order within each byte (pure wiring).
  function automatic logic [63:0] reflect_bytes(input logic [63:0] v);
    logic [63:0] r;
    for (int b = 0; b < 8; b++) begin
      for (int k = 0; k < 8; k++) begin
        r[b*8 + k] = v[b*8 + 7 - k];
      end
    end
    return r;
  endfunction

  // One digit of the Horner multiply, high coefficient bit first.
  function automatic logic [127:0] gf_digit_step(input logic [127:0] r_in,
                                                 input logic [127:0] a,
                                                 input logic [DIGIT_BITS-1:0] d);
    logic [127:0] r;
    r = r_in;
    for (int k = DIGIT_BITS - 1; k >= 0; k--) begin
      r = {r[126:0], 1'b0} ^ (r[127] ? {120'd0, REDUCE_POLY} : 128'd0);
      if (d[k]) r = r ^ a;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/ghash_block_update_top.sv
// GHASH accumulator update: absorb, multiply by key, or load, with a digit-serial multiplier.
//
// Each item takes the input handshake. Absorb and multiply then run the 8-bit-per-cycle
// GF(2^128) multiplier in state MUL and move the result into the output register in
// state HOLD; a load goes straight to HOLD. HOLD waits while an unread result still
// sits in the output register. in_ready is high only while no item is in progress,
// but a finished result may sit in the output register while the next item is
// taken. The key is written through cfg_we/cfg_index/cfg_wdata; write it only while
// idle, which the block itself does not enforce. Index 0 is the low key word, index 1
// the high one, others are ignored. No clearing pass is needed after reset.
`default_nettype none
`include "ghash_block_update_top_macros.svh"
module ghash_block_update_top
  import gbu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire gbu_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output gbu_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  gbu_state_t       state_r, state_nxt;
  logic [63:0]      key_lo_r, key_hi_r;
  logic [127:0]     acc_r, acc_nxt;       // {high, low} in byte order
  logic [127:0]     a_r, a_nxt;           // reflected multiplicand
  logic [127:0]     b_r, b_nxt;           // reflected key, shifted out a digit a cycle
  logic [127:0]     prod_r, prod_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  gbu_out_t         out_data_r, out_data_nxt;
  logic             in_acc;
  logic [63:0]      x_lo, x_hi;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0;
      key_hi_r <= '0;
    end else if (cfg_we && (cfg_index[1] == 1'b0)) begin
      if (cfg_index[0] == CFG_KEY_LOW) key_lo_r <= cfg_wdata;
      if (cfg_index[0] == CFG_KEY_HIGH) key_hi_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    prod_nxt      = prod_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    x_lo          = acc_r[63:0];
    x_hi          = acc_r[127:64];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.op)
            OP_ABSORB: begin
              x_lo      = acc_r[63:0] ^ in_data.block_low;
              x_hi      = acc_r[127:64] ^ in_data.block_high;
              state_nxt = ST_MUL;
            end
            OP_MULTIPLY: state_nxt = ST_MUL;
            OP_LOAD: begin
              acc_nxt   = {in_data.block_high, in_data.block_low};
              state_nxt = ST_HOLD;
            end
            default: state_nxt = ST_HOLD;  // unused code: accumulator unchanged
          endcase
          a_nxt    = {reflect_bytes(x_hi), reflect_bytes(x_lo)};
          b_nxt    = {reflect_bytes(key_hi_r), reflect_bytes(key_lo_r)};
          prod_nxt = '0;
          cnt_nxt  = '0;
        end
      end
      ST_MUL: begin
        prod_nxt = gf_digit_step(prod_r, a_r, b_r[127 -: DIGIT_BITS]);
        b_nxt    = {b_r[127-DIGIT_BITS:0], {DIGIT_BITS{1'b0}}};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          acc_nxt   = {reflect_bytes(prod_nxt[127:64]), reflect_bytes(prod_nxt[63:0])};
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = '{acc_low: acc_r[63:0], acc_high: acc_r[127:64]};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `GBU_ASSERT_NEXT(a_mul_start, clk, rst_n,
    in_acc && (in_data.op == OP_ABSORB || in_data.op == OP_MULTIPLY),
    state_r == ST_MUL && cnt_r == '0)
  `GBU_ASSERT_NEXT(a_mul_end, clk, rst_n,
    state_r == ST_MUL && cnt_r == CNT_LAST, state_r == ST_HOLD)
  `GBU_ASSERT_NEXT(a_load, clk, rst_n, in_acc && in_data.op == OP_LOAD,
    acc_r == {$past(in_data.block_high), $past(in_data.block_low)})
  `GBU_ASSERT_NEXT(a_publish, clk, rst_n,
    state_r == ST_HOLD && (!out_valid_r || out_ready),
    out_valid_r && out_data_r.acc_low == $past(acc_r[63:0]))

endmodule
`default_nettype wire
